// ===== sv/urs_pkg.sv =====
// ----------------------------------------------------------------------------
// urs_pkg
// Shared types and codes for the undo/redo stack pair: opcodes, decoded
// command beat, status codes and the result beat.
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int VALUE_W = 32;

  localparam logic [2:0] OP_ADD   = 3'd0;
  localparam logic [2:0] OP_UNDO  = 3'd1;
  localparam logic [2:0] OP_REDO  = 3'd2;
  localparam logic [2:0] OP_CLEAR = 3'd3;
  localparam logic [2:0] OP_DUMP  = 3'd4;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_NOTHING = 2'd3;

  localparam logic STK_UNDO = 1'b0;
  localparam logic STK_REDO = 1'b1;

  typedef enum logic [2:0] {
    CMD_ADD,
    CMD_UNDO,
    CMD_REDO,
    CMD_CLEAR,
    CMD_DUMP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [VALUE_W-1:0]   value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 which;
    logic [VALUE_W-1:0]   entry;
    logic [3:0]           position;
    logic [4:0]           undo_depth;
    logic [4:0]           redo_depth;
    logic                 last;
  } result_t;

endpackage

// ===== sv/urs_fifo.sv =====
// ----------------------------------------------------------------------------
// urs_fifo
// Two-entry queue used between front and back and on the result side.
// ----------------------------------------------------------------------------
module urs_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  logic [WIDTH-1:0] slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(do_push) - 2'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot[wr_ptr] <= din;
  end

endmodule

// ===== sv/urs_front.sv =====
// ----------------------------------------------------------------------------
// urs_front
// Input side: takes operation beats, decodes the opcode into a command and
// queues it for the back end. Reserved opcodes are taken and discarded.
// ----------------------------------------------------------------------------
module urs_front (
  input  logic                       push,
  output logic                       full,
  input  logic [2:0]                 operation,
  input  logic [urs_pkg::VALUE_W-1:0] entry_value,
  output logic                       cmd_push,
  output urs_pkg::cmd_t              cmd,
  input  logic                       cmd_full
);

  logic op_ok;

  always_comb begin
    op_ok    = 1'b1;
    cmd.kind = urs_pkg::CMD_ADD;
    case (operation)
      urs_pkg::OP_ADD:   cmd.kind = urs_pkg::CMD_ADD;
      urs_pkg::OP_UNDO:  cmd.kind = urs_pkg::CMD_UNDO;
      urs_pkg::OP_REDO:  cmd.kind = urs_pkg::CMD_REDO;
      urs_pkg::OP_CLEAR: cmd.kind = urs_pkg::CMD_CLEAR;
      urs_pkg::OP_DUMP:  cmd.kind = urs_pkg::CMD_DUMP;
      default:           op_ok    = 1'b0;
    endcase
    cmd.value = entry_value;
  end

  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && op_ok;

endmodule

// ===== sv/urs_back.sv =====
// ----------------------------------------------------------------------------
// urs_back
// Execution side: owns the shared entry store and both stack counts, runs
// one command at a time and writes result beats into the result queue.
// ----------------------------------------------------------------------------
module urs_back #(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_empty,
  input  urs_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             res_full,
  output logic             res_push,
  output urs_pkg::result_t res
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  // only the low min(ENTRY_WIDTH, 32) input bits can ever be stored
  localparam int SW = (ENTRY_WIDTH < urs_pkg::VALUE_W) ? ENTRY_WIDTH : urs_pkg::VALUE_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MOVE,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] undo_count, undo_count_next;
  logic [CW-1:0] redo_count, redo_count_next;
  logic [CW-1:0] idx, idx_next;
  logic          phase, phase_next;     // dump walk: 0 undo, 1 redo
  logic          mv_undo, mv_undo_next; // pending move direction

  logic [SW-1:0] store [DEPTH];
  logic [SW-1:0] mem_rdata;
  logic          mem_we, mem_re;
  logic [CW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata;

  logic [CW:0]   used;
  logic [CW-1:0] cur_cnt;
  logic          at_end;

  assign used    = {1'b0, undo_count} + {1'b0, redo_count};
  assign cur_cnt = phase ? redo_count : undo_count;
  assign at_end  = (idx == cur_cnt - CW'(1));

  always_comb begin
    state_next      = state;
    undo_count_next = undo_count;
    redo_count_next = redo_count;
    idx_next        = idx;
    phase_next      = phase;
    mv_undo_next    = mv_undo;
    cmd_pop         = 1'b0;
    res_push        = 1'b0;
    res             = '0;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = cmd.value[SW-1:0];
    mem_re          = 1'b0;
    mem_raddr       = '0;

    case (state)
      S_IDLE: begin
        if (!cmd_empty && !res_full) begin
          cmd_pop = 1'b1;
          case (cmd.kind)
            urs_pkg::CMD_ADD: begin
              res_push = 1'b1;
              res.last = 1'b1;
              res.which = urs_pkg::STK_UNDO;
              if (used >= (CW+1)'(DEPTH)) begin
                res.status = urs_pkg::ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = undo_count;
                undo_count_next = undo_count + CW'(1);
                res.status      = urs_pkg::ST_OK;
                res.entry       = urs_pkg::VALUE_W'(cmd.value[SW-1:0]);
              end
            end
            urs_pkg::CMD_UNDO: begin
              if (undo_count == '0) begin
                res_push   = 1'b1;
                res.last   = 1'b1;
                res.status = urs_pkg::ST_EMPTY;
                res.which  = urs_pkg::STK_UNDO;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = undo_count - CW'(1);
                mv_undo_next = 1'b1;
                state_next   = S_MOVE;
              end
            end
            urs_pkg::CMD_REDO: begin
              if (redo_count == '0) begin
                res_push   = 1'b1;
                res.last   = 1'b1;
                res.status = urs_pkg::ST_EMPTY;
                res.which  = urs_pkg::STK_REDO;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = CW'(DEPTH) - redo_count;
                mv_undo_next = 1'b0;
                state_next   = S_MOVE;
              end
            end
            urs_pkg::CMD_CLEAR: begin
              undo_count_next = '0;
              redo_count_next = '0;
              res_push        = 1'b1;
              res.last        = 1'b1;
              res.status      = urs_pkg::ST_OK;
            end
            urs_pkg::CMD_DUMP: begin
              if (used == '0) begin
                res_push   = 1'b1;
                res.last   = 1'b1;
                res.status = urs_pkg::ST_NOTHING;
              end else begin
                phase_next = (undo_count == '0);
                idx_next   = '0;
                state_next = S_DUMP_RD;
              end
            end
            default: ;
          endcase
          // depths reported after this step
          res.undo_depth = 5'(undo_count_next);
          res.redo_depth = 5'(redo_count_next);
        end
      end

      S_MOVE: begin
        if (!res_full) begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          if (mv_undo) begin
            mem_waddr       = CW'(DEPTH - 1) - redo_count;
            undo_count_next = undo_count - CW'(1);
            redo_count_next = redo_count + CW'(1);
            res.which       = urs_pkg::STK_REDO;
          end else begin
            mem_waddr       = undo_count;
            undo_count_next = undo_count + CW'(1);
            redo_count_next = redo_count - CW'(1);
            res.which       = urs_pkg::STK_UNDO;
          end
          res_push       = 1'b1;
          res.status     = urs_pkg::ST_OK;
          res.entry      = urs_pkg::VALUE_W'(mem_rdata);
          res.last       = 1'b1;
          res.undo_depth = 5'(undo_count_next);
          res.redo_depth = 5'(redo_count_next);
          state_next     = S_IDLE;
        end
      end

      S_DUMP_RD: begin
        mem_re     = 1'b1;
        mem_raddr  = phase ? (CW'(DEPTH) - redo_count + idx)
                           : (undo_count - CW'(1) - idx);
        state_next = S_DUMP_OUT;
      end

      S_DUMP_OUT: begin
        if (!res_full) begin
          res_push       = 1'b1;
          res.status     = urs_pkg::ST_OK;
          res.which      = phase;
          res.entry      = urs_pkg::VALUE_W'(mem_rdata);
          res.position   = 4'(idx);
          res.undo_depth = 5'(undo_count);
          res.redo_depth = 5'(redo_count);
          res.last       = at_end && (phase || redo_count == '0);
          if (!at_end) begin
            idx_next   = idx + CW'(1);
            state_next = S_DUMP_RD;
          end else if (!phase && redo_count != '0) begin
            phase_next = 1'b1;
            idx_next   = '0;
            state_next = S_DUMP_RD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      undo_count <= '0;
      redo_count <= '0;
      idx        <= '0;
      phase      <= 1'b0;
      mv_undo    <= 1'b0;
    end else begin
      state      <= state_next;
      undo_count <= undo_count_next;
      redo_count <= redo_count_next;
      idx        <= idx_next;
      phase      <= phase_next;
      mv_undo    <= mv_undo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store[mem_waddr[AW-1:0]] <= mem_wdata;
    if (mem_re) mem_rdata <= store[mem_raddr[AW-1:0]];
  end

  a_occupancy: assert property (@(posedge clk) disable iff (rst)
    used <= (CW+1)'(DEPTH))
    else $error("stack occupancy exceeds store depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result beat written into full queue");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && cmd_pop && cmd.kind == urs_pkg::CMD_CLEAR)
    |=> (undo_count == '0 && redo_count == '0))
    else $error("clear left entries on a stack");

  a_dump_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_DUMP_OUT && res_push && res.last) |=> (state == S_IDLE))
    else $error("dump walk continued past its last beat");

endmodule

// ===== sv/undo_redo_stack_pair_core.sv =====
// ----------------------------------------------------------------------------
// undo_redo_stack_pair_core
// Undo and redo stacks sharing one store of DEPTH entries.
// ----------------------------------------------------------------------------
// Input channel: push/full, one beat per operation (operation, entry_value).
// Result channel: empty/pop, result fields valid while empty is low.
// A front decoder drops reserved opcodes and queues commands in a two-entry
// queue; the back end executes them against the entry store, a single-port
// write / registered-read memory, and fills a two-entry result queue.
// In the back end, add, clear and the empty-stack cases complete in the idle
// state; undo and redo read the store, then write to the other stack; dump
// reads the store once per listed entry, then sends that entry's result.
// Each command's first result reaches the ports through the command queue,
// the back end and the result queue, after any store read that it needs.
// Dump gives one result per entry, last marks the final beat of a command.
// Reset (rst, synchronous) empties both stacks and both queues.
// When pop is held low the result queue fills, the back end waits, and once
// the command queue is full the full output rises; nothing is dropped.
// ----------------------------------------------------------------------------
module undo_redo_stack_pair_core #(
  parameter int DEPTH       = 16,
  parameter int ENTRY_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  operation,
  input  logic [31:0] entry_value,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        which_stack,
  output logic [31:0] entry_out,
  output logic [3:0]  position,
  output logic [4:0]  undo_depth,
  output logic [4:0]  redo_depth,
  output logic        last
);

  localparam int CMD_W = $bits(urs_pkg::cmd_t);
  localparam int RES_W = $bits(urs_pkg::result_t);

  urs_pkg::cmd_t    cmd_in, cmd_out;
  urs_pkg::result_t res_in, res_out;
  logic [CMD_W-1:0] cmd_bits;
  logic [RES_W-1:0] res_bits;
  logic             cmd_push, cmd_full, cmd_empty, cmd_pop;
  logic             res_push, res_full;

  urs_front u_front (
    .push        (push),
    .full        (full),
    .operation   (operation),
    .entry_value (entry_value),
    .cmd_push    (cmd_push),
    .cmd         (cmd_in),
    .cmd_full    (cmd_full)
  );

  urs_fifo #(.WIDTH(CMD_W)) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .din   (cmd_in),
    .full  (cmd_full),
    .pop   (cmd_pop),
    .dout  (cmd_bits),
    .empty (cmd_empty)
  );

  assign cmd_out = urs_pkg::cmd_t'(cmd_bits);

  urs_back #(.DEPTH(DEPTH), .ENTRY_WIDTH(ENTRY_WIDTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_empty (cmd_empty),
    .cmd       (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  urs_fifo #(.WIDTH(RES_W)) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .din   (res_in),
    .full  (res_full),
    .pop   (pop),
    .dout  (res_bits),
    .empty (empty)
  );

  assign res_out     = urs_pkg::result_t'(res_bits);
  assign status      = res_out.status;
  assign which_stack = res_out.which;
  assign entry_out   = res_out.entry;
  assign position    = res_out.position;
  assign undo_depth  = res_out.undo_depth;
  assign redo_depth  = res_out.redo_depth;
  assign last        = res_out.last;

endmodule

// ===== sim/undo_redo_stack_pair_core_test.sv =====
// ----------------------------------------------------------------------------
// undo_redo_stack_pair_core_test
// Self-checking bench for the undo/redo stack pair. A short scripted
// sequence covers empty stacks, extreme entry words, spare opcodes, clear
// and dump. Random episodes follow, some of which fill the store to
// overflow and drain it again. Every result beat is checked against a
// behavioral copy of both stacks. Gaps on push and stalls on pop are random.
// ----------------------------------------------------------------------------
module undo_redo_stack_pair_core_test;

  localparam int SLOTS = 16;
  localparam int IW = $clog2(SLOTS);
  localparam int RANDOM_ITEMS = 260;
  localparam int SETTLE_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  // opcodes the block must drop silently
  localparam logic [2:0] OP_RSVD5 = 3'd5;
  localparam logic [2:0] OP_RSVD6 = 3'd6;
  localparam logic [2:0] OP_RSVD7 = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [2:0]  operation = urs_pkg::OP_ADD;
  logic [31:0] entry_value = '0;
  logic        pop = 1'b0;
  logic        full;
  logic        empty;
  logic [1:0]  status;
  logic        which_stack;
  logic [31:0] entry_out;
  logic [3:0]  position;
  logic [4:0]  undo_depth;
  logic [4:0]  redo_depth;
  logic        last;

  typedef struct {
    logic [2:0]       op;
    logic [31:0]      value;
    bit               typed;
    urs_pkg::result_t want;
  } script_row_t;

  // shadow of the two stacks
  logic [31:0] hist_store [SLOTS];
  int unsigned undo_cnt = 0;
  int unsigned redo_cnt = 0;

  urs_pkg::result_t pending_results [$];
  script_row_t      script [$];
  int               fail_count = 0;
  int               items_sent = 0;
  bit               calm = 1'b0;

  undo_redo_stack_pair_core #(
    .DEPTH      (SLOTS),
    .ENTRY_WIDTH(32)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .operation  (operation),
    .entry_value(entry_value),
    .empty      (empty),
    .pop        (pop),
    .status     (status),
    .which_stack(which_stack),
    .entry_out  (entry_out),
    .position   (position),
    .undo_depth (undo_depth),
    .redo_depth (redo_depth),
    .last       (last)
  );

  always #2 clk = ~clk;

  function automatic urs_pkg::result_t make_beat(logic [1:0] st, logic stk,
                                                 logic [31:0] ent, logic [3:0] pos,
                                                 logic fin);
    urs_pkg::result_t r;
    r.status     = st;
    r.which      = stk;
    r.entry      = ent;
    r.position   = pos;
    r.undo_depth = 5'(undo_cnt);
    r.redo_depth = 5'(redo_cnt);
    r.last       = fin;
    return r;
  endfunction

  // single-beat expectation with depths spelled out
  function automatic urs_pkg::result_t fixed_beat(logic [1:0] st, logic stk,
                                                  logic [31:0] ent,
                                                  logic [4:0] ud, logic [4:0] rd);
    urs_pkg::result_t r;
    r.status     = st;
    r.which      = stk;
    r.entry      = ent;
    r.position   = '0;
    r.undo_depth = ud;
    r.redo_depth = rd;
    r.last       = 1'b1;
    return r;
  endfunction

  function automatic script_row_t row(logic [2:0] op, logic [31:0] val, bit typed,
                                      urs_pkg::result_t want);
    script_row_t s;
    s.op    = op;
    s.value = val;
    s.typed = typed;
    s.want  = want;
    return s;
  endfunction

  task automatic predict_history_step(input logic [2:0] op, input logic [31:0] val);
    logic [31:0] moved;
    case (op)
      urs_pkg::OP_ADD: begin
        if (undo_cnt + redo_cnt >= SLOTS) begin
          pending_results.push_back(make_beat(urs_pkg::ST_FULL, urs_pkg::STK_UNDO,
                                              '0, '0, 1'b1));
        end else begin
          hist_store[IW'(undo_cnt)] = val;
          undo_cnt++;
          pending_results.push_back(make_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO,
                                              val, '0, 1'b1));
        end
      end
      urs_pkg::OP_UNDO: begin
        if (undo_cnt == 0) begin
          pending_results.push_back(make_beat(urs_pkg::ST_EMPTY, urs_pkg::STK_UNDO,
                                              '0, '0, 1'b1));
        end else begin
          undo_cnt--;
          moved = hist_store[IW'(undo_cnt)];
          hist_store[IW'(SLOTS - 1 - redo_cnt)] = moved;
          redo_cnt++;
          pending_results.push_back(make_beat(urs_pkg::ST_OK, urs_pkg::STK_REDO,
                                              moved, '0, 1'b1));
        end
      end
      urs_pkg::OP_REDO: begin
        if (redo_cnt == 0) begin
          pending_results.push_back(make_beat(urs_pkg::ST_EMPTY, urs_pkg::STK_REDO,
                                              '0, '0, 1'b1));
        end else begin
          redo_cnt--;
          moved = hist_store[IW'(SLOTS - 1 - redo_cnt)];
          hist_store[IW'(undo_cnt)] = moved;
          undo_cnt++;
          pending_results.push_back(make_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO,
                                              moved, '0, 1'b1));
        end
      end
      urs_pkg::OP_CLEAR: begin
        undo_cnt = 0;
        redo_cnt = 0;
        pending_results.push_back(make_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO,
                                            '0, '0, 1'b1));
      end
      urs_pkg::OP_DUMP: begin
        if (undo_cnt == 0 && redo_cnt == 0) begin
          pending_results.push_back(make_beat(urs_pkg::ST_NOTHING, urs_pkg::STK_UNDO,
                                              '0, '0, 1'b1));
        end else begin
          // undo top first, then redo top first; last flag on the final beat
          for (int i = 0; i < int'(undo_cnt); i++)
            pending_results.push_back(make_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO,
              hist_store[IW'(undo_cnt - 1 - i)], 4'(i),
              (i == int'(undo_cnt) - 1) && (redo_cnt == 0)));
          for (int i = 0; i < int'(redo_cnt); i++)
            pending_results.push_back(make_beat(urs_pkg::ST_OK, urs_pkg::STK_REDO,
              hist_store[IW'(SLOTS - redo_cnt + i)], 4'(i), i == int'(redo_cnt) - 1));
        end
      end
      default: ;
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%s", msg);
  endtask

  task automatic send_beat(input logic [2:0] op, input logic [31:0] val);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push        <= 1'b1;
    operation   <= op;
    entry_value <= val;
    @(posedge clk);
    while (full) @(posedge clk);
    predict_history_step(op, val);
    if (op <= urs_pkg::OP_DUMP) items_sent++;
  endtask

  task automatic check_result();
    urs_pkg::result_t want;
    if (pending_results.size() == 0) begin
      note_failure($sformatf("unexpected result beat: st=%0d stk=%0d ent=%h pos=%0d",
                             status, which_stack, entry_out, position));
      return;
    end
    want = pending_results.pop_front();
    if (status !== want.status || which_stack !== want.which || entry_out !== want.entry ||
        position !== want.position || undo_depth !== want.undo_depth ||
        redo_depth !== want.redo_depth || last !== want.last)
      note_failure($sformatf(
        {"mismatch: exp st=%0d stk=%0d ent=%h pos=%0d ud=%0d rd=%0d last=%0d, ",
         "got st=%0d stk=%0d ent=%h pos=%0d ud=%0d rd=%0d last=%0d"},
        want.status, want.which, want.entry, want.position, want.undo_depth,
        want.redo_depth, want.last, status, which_stack, entry_out, position,
        undo_depth, redo_depth, last));
  endtask

  task automatic random_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)      send_beat(urs_pkg::OP_ADD, $urandom());
    else if (r < 62) send_beat(urs_pkg::OP_UNDO, $urandom());
    else if (r < 84) send_beat(urs_pkg::OP_REDO, $urandom());
    else if (r < 93) send_beat(urs_pkg::OP_DUMP, $urandom());
    else if (r < 96) send_beat(urs_pkg::OP_CLEAR, $urandom());
    else             send_beat(3'(OP_RSVD5 + $urandom_range(0, 2)), $urandom());
  endtask

  // fill to overflow, list the full store, then optionally drain both ways
  task automatic fill_episode();
    send_beat(urs_pkg::OP_CLEAR, $urandom());
    while (undo_cnt + redo_cnt < SLOTS) begin
      if (undo_cnt > 0 && $urandom_range(0, 3) == 0) send_beat(urs_pkg::OP_UNDO, $urandom());
      else send_beat(urs_pkg::OP_ADD, $urandom());
    end
    repeat ($urandom_range(1, 2)) send_beat(urs_pkg::OP_ADD, $urandom());
    send_beat(urs_pkg::OP_DUMP, $urandom());
    if ($urandom_range(0, 1) == 1) begin
      while (undo_cnt > 0) send_beat(urs_pkg::OP_UNDO, $urandom());
      send_beat(urs_pkg::OP_UNDO, $urandom());
      send_beat(urs_pkg::OP_DUMP, $urandom());
      while (redo_cnt > 0) send_beat(urs_pkg::OP_REDO, $urandom());
      send_beat(urs_pkg::OP_REDO, $urandom());
    end
  endtask

  // result side: random pop stalls, check at every accepted beat
  initial begin
    int hold;
    hold = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (pop && !empty) check_result();
      if (hold > 0) begin
        pop <= 1'b0;
        hold--;
      end else begin
        pop  <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  initial begin
    script.push_back(row(urs_pkg::OP_DUMP, '0, 1'b1,
      fixed_beat(urs_pkg::ST_NOTHING, urs_pkg::STK_UNDO, '0, 5'd0, 5'd0)));
    script.push_back(row(urs_pkg::OP_UNDO, '1, 1'b1,
      fixed_beat(urs_pkg::ST_EMPTY, urs_pkg::STK_UNDO, '0, 5'd0, 5'd0)));
    script.push_back(row(urs_pkg::OP_REDO, '1, 1'b1,
      fixed_beat(urs_pkg::ST_EMPTY, urs_pkg::STK_REDO, '0, 5'd0, 5'd0)));
    script.push_back(row(urs_pkg::OP_ADD, 32'hFFFF_FFFF, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO, 32'hFFFF_FFFF, 5'd1, 5'd0)));
    script.push_back(row(urs_pkg::OP_ADD, 32'h0000_0000, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO, '0, 5'd2, 5'd0)));
    script.push_back(row(OP_RSVD5, 32'h1234_5678, 1'b0, '0));
    script.push_back(row(OP_RSVD6, 32'hFFFF_FFFF, 1'b0, '0));
    script.push_back(row(OP_RSVD7, 32'h0000_0000, 1'b0, '0));
    script.push_back(row(urs_pkg::OP_ADD, 32'hA5A5_5A5A, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO, 32'hA5A5_5A5A, 5'd3, 5'd0)));
    script.push_back(row(urs_pkg::OP_UNDO, '0, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_REDO, 32'hA5A5_5A5A, 5'd2, 5'd1)));
    script.push_back(row(urs_pkg::OP_UNDO, '0, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_REDO, '0, 5'd1, 5'd2)));
    script.push_back(row(urs_pkg::OP_DUMP, '0, 1'b0, '0));
    script.push_back(row(urs_pkg::OP_REDO, '0, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO, '0, 5'd2, 5'd1)));
    // add leaves the redo stack alone
    script.push_back(row(urs_pkg::OP_ADD, 32'h8000_0001, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO, 32'h8000_0001, 5'd3, 5'd1)));
    script.push_back(row(urs_pkg::OP_DUMP, '1, 1'b0, '0));
    script.push_back(row(urs_pkg::OP_CLEAR, '1, 1'b1,
      fixed_beat(urs_pkg::ST_OK, urs_pkg::STK_UNDO, '0, 5'd0, 5'd0)));
    script.push_back(row(urs_pkg::OP_DUMP, '0, 1'b1,
      fixed_beat(urs_pkg::ST_NOTHING, urs_pkg::STK_UNDO, '0, 5'd0, 5'd0)));
    script.push_back(row(urs_pkg::OP_REDO, '0, 1'b1,
      fixed_beat(urs_pkg::ST_EMPTY, urs_pkg::STK_REDO, '0, 5'd0, 5'd0)));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      send_beat(script[k].op, script[k].value);
      if (script[k].typed) begin
        void'(pending_results.pop_back());
        pending_results.push_back(script[k].want);
      end
    end

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        fill_episode();
      end else begin
        repeat ($urandom_range(8, 30)) random_op();
      end
    end
    calm = 1'b0;
    push <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      note_failure($sformatf("%0d result beats never arrived", pending_results.size()));

    if (fail_count == 0) begin
      $display("** undo_redo_stack_pair_core: PASSED **");
    end else begin
      $display("** undo_redo_stack_pair_core: FAILED **");
    end
    $finish;
  end

  // hang guard
  initial begin
    #6_000_000;
    $display("** undo_redo_stack_pair_core: FAILED **");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/urs_pkg.sv
sv/urs_fifo.sv
sv/urs_front.sv
sv/urs_back.sv
sv/undo_redo_stack_pair_core.sv
sim/undo_redo_stack_pair_core_test.sv
